// File: design/apq_pkg.sv
// Shared types and constants for the adaptive palette quantizer.
`timescale 1ns / 1ps
package apq_pkg;

    localparam int COLOR_W = 8;
    localparam int THR_W   = 16;
    localparam int DIST_W  = 16;
    localparam int SQ_W    = 16;
    localparam int SUM_W   = 23;
    localparam int BLACK_W = 16;
    localparam int RUN_OUT_W = 17;
    localparam int IDX_OUT_W = 8;

    localparam logic [THR_W-1:0]   THR_RESET = 16'd100;
    localparam logic [BLACK_W-1:0] BLACK_MAX = 16'hFFFF;

    // Channel weights in hundredths
    localparam logic [6:0] W_BLUE  = 7'd11;
    localparam logic [6:0] W_GREEN = 7'd59;
    localparam logic [6:0] W_RED   = 7'd30;

    // floor(s / 100) = (s * RECIP) >> RECIP_SHIFT, exact for s below 2^23
    localparam int RECIP_W     = 24;
    localparam int RECIP_SHIFT = 30;
    localparam logic [RECIP_W-1:0] RECIP = 24'd10737419;
    localparam int PROD_W      = SUM_W + RECIP_W;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;      // capture the input item
        logic init;      // open a new image with this pixel as entry 0
        logic scan;      // start the nearest-color search
        logic black;     // update the black pixel count
        logic run;       // close or extend the current run
        logic add;       // append the color or flag the full palette
        logic fin;       // flush the final run and empty the palette
        logic emit;      // load the output register with the record
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic first;     // item opens a new image
        logic last;      // item closes the image
        logic scan_done; // search finished, best index valid
        logic run_brk;   // nearest index differs from the previous one
        logic add_req;   // best distance at or above the threshold
        logic has_room;  // palette not yet full
        logic out_free;  // output register can take a record
    } dp_status_t;

endpackage

// File: design/apq_ctrl.sv
// Controller state machine that sequences one pixel through search and record output.
`timescale 1ns / 1ps
module apq_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  apq_pkg::dp_status_t status,
    output apq_pkg::dp_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_BLACK = 3'd3;
    localparam logic [2:0] ST_RUN   = 3'd4;
    localparam logic [2:0] ST_ADD   = 3'd5;
    localparam logic [2:0] ST_FINAL = 3'd6;
    localparam logic [2:0] ST_INIT  = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Advance the state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Decode commands and the next state
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                if (status.first) begin
                    state_next = ST_INIT;
                end else begin
                    cmd.scan   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (status.scan_done) begin
                    state_next = ST_BLACK;
                end
            end
            ST_BLACK: begin
                cmd.black  = 1'b1;
                state_next = ST_RUN;
            end
            ST_RUN: begin
                if (!status.run_brk) begin
                    cmd.run    = 1'b1;
                    state_next = ST_ADD;
                end else if (status.out_free) begin
                    cmd.run    = 1'b1;
                    cmd.emit   = 1'b1;
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                if (!status.add_req) begin
                    state_next = ST_FINAL;
                end else if (!status.has_room) begin
                    cmd.add    = 1'b1;
                    state_next = ST_FINAL;
                end else if (status.out_free) begin
                    cmd.add    = 1'b1;
                    cmd.emit   = 1'b1;
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                if (!status.last) begin
                    state_next = ST_IDLE;
                end else if (status.out_free) begin
                    cmd.fin    = 1'b1;
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_INIT: begin
                if (status.out_free) begin
                    cmd.init   = 1'b1;
                    cmd.emit   = 1'b1;
                    state_next = ST_FINAL;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: design/apq_dp.sv
// Datapath: palette memory, pipelined distance search, run and black counters, output register.
`timescale 1ns / 1ps
module apq_dp #(
    parameter int PALETTE_DEPTH = 256,
    parameter int IMAGE_PIXELS  = 65536
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [15:0]              cfg_wdata,
    input  logic [7:0]               s_blue,
    input  logic [7:0]               s_green,
    input  logic [7:0]               s_red,
    input  logic                     s_first_pixel,
    input  logic                     s_last_pixel,
    input  apq_pkg::dp_cmd_t         cmd,
    output apq_pkg::dp_status_t      status,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_kind,
    output logic [7:0]               m_entry_index,
    output logic [16:0]              m_run_length,
    output logic [7:0]               m_entry_blue,
    output logic [7:0]               m_entry_green,
    output logic [7:0]               m_entry_red,
    output logic [15:0]              m_black_count,
    output logic                     m_palette_full,
    output logic                     m_final_record
);

    localparam int IW = $clog2(PALETTE_DEPTH);
    localparam int CW = $clog2(PALETTE_DEPTH + 1);
    localparam int RW = $clog2(IMAGE_PIXELS + 1);
    localparam int CLR_W = 3 * apq_pkg::COLOR_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(PALETTE_DEPTH);
    localparam logic [RW-1:0] RUN_MAX = RW'(IMAGE_PIXELS);

    // Palette memory
    logic [CLR_W-1:0] pal_mem [PALETTE_DEPTH];
    logic [CLR_W-1:0] rd_reg;

    // Pixel and control state
    logic [7:0]   pix_b_reg, pix_g_reg, pix_r_reg;
    logic         first_reg, last_reg;
    logic [15:0]  thr_reg;
    logic [CW-1:0] count_reg;
    logic [IW-1:0] prev_reg;
    logic [RW-1:0] run_reg;
    logic [15:0]  black_reg;
    logic         refused_reg;

    // Search pipeline
    logic          issuing_reg;
    logic [IW-1:0] k_reg;
    logic          v1_reg, v2_reg, v3_reg, v4_reg;
    logic [IW-1:0] idx1_reg, idx2_reg, idx3_reg, idx4_reg;
    logic          blk2_reg, blk3_reg, blk4_reg;
    logic [15:0]   sqb_reg, sqg_reg, sqr_reg;
    logic [apq_pkg::SUM_W-1:0] sum_reg;
    logic [15:0]   d4_reg;
    logic [IW-1:0] best_reg;
    logic [15:0]   bestd_reg;
    logic          bestblk_reg;

    logic [7:0] db, dg, dr;
    logic [apq_pkg::PROD_W-1:0] prod;
    logic blk1;

    // Output register
    logic        m_valid_reg;
    logic        kind_reg;
    logic [7:0]  idx_out_reg;
    logic [16:0] run_out_reg;
    logic [7:0]  ob_reg, og_reg, or_reg;
    logic [15:0] black_out_reg;
    logic        full_out_reg;
    logic        fin_out_reg;

    // Record fields
    logic          rec_kind;
    logic [IW-1:0] rec_idx;
    logic [RW-1:0] rec_run;
    logic [7:0]    rec_b, rec_g, rec_r;
    logic [15:0]   rec_black;
    logic          rec_full;
    logic          rec_fin;
    logic [IW+7:0] idx_ext;
    logic [RW+16:0] run_ext;

    logic          mem_we;
    logic [IW-1:0] mem_waddr;

    // Capture the item and the threshold
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            pix_b_reg <= s_blue;
            pix_g_reg <= s_green;
            pix_r_reg <= s_red;
            first_reg <= s_first_pixel;
            last_reg  <= s_last_pixel;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= apq_pkg::THR_RESET;
        end else if (cfg_we) begin
            thr_reg <= cfg_wdata;
        end
    end

    // Memory write port and registered read
    assign mem_we    = cmd.init || (cmd.add && (count_reg < DEPTH_C));
    assign mem_waddr = cmd.init ? '0 : count_reg[IW-1:0];

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            pal_mem[mem_waddr] <= {pix_b_reg, pix_g_reg, pix_r_reg};
        end
        rd_reg <= pal_mem[k_reg];
    end

    // Issue addresses through the palette
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issuing_reg <= 1'b0;
            k_reg       <= '0;
        end else if (cmd.scan) begin
            issuing_reg <= 1'b1;
            k_reg       <= '0;
        end else if (issuing_reg) begin
            if (CW'(k_reg) == count_reg - 1'b1) begin
                issuing_reg <= 1'b0;
            end else begin
                k_reg <= k_reg + 1'b1;
            end
        end
    end

    // Absolute differences and black test on the read entry
    assign db   = (pix_b_reg > rd_reg[23:16]) ? pix_b_reg - rd_reg[23:16]
                                              : rd_reg[23:16] - pix_b_reg;
    assign dg   = (pix_g_reg > rd_reg[15:8]) ? pix_g_reg - rd_reg[15:8]
                                             : rd_reg[15:8] - pix_g_reg;
    assign dr   = (pix_r_reg > rd_reg[7:0]) ? pix_r_reg - rd_reg[7:0]
                                            : rd_reg[7:0] - pix_r_reg;
    assign blk1 = (rd_reg == '0);
    assign prod = apq_pkg::PROD_W'(sum_reg) * apq_pkg::PROD_W'(apq_pkg::RECIP);

    // Square, weight, scale by 1/100
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= issuing_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        idx1_reg <= k_reg;
        idx2_reg <= idx1_reg;
        idx3_reg <= idx2_reg;
        idx4_reg <= idx3_reg;
        blk2_reg <= blk1;
        blk3_reg <= blk2_reg;
        blk4_reg <= blk3_reg;
        sqb_reg  <= db * db;
        sqg_reg  <= dg * dg;
        sqr_reg  <= dr * dr;
        sum_reg  <= apq_pkg::SUM_W'(sqb_reg) * apq_pkg::SUM_W'(apq_pkg::W_BLUE)
                  + apq_pkg::SUM_W'(sqg_reg) * apq_pkg::SUM_W'(apq_pkg::W_GREEN)
                  + apq_pkg::SUM_W'(sqr_reg) * apq_pkg::SUM_W'(apq_pkg::W_RED);
        d4_reg   <= prod[apq_pkg::RECIP_SHIFT +: apq_pkg::DIST_W];
    end

    // Keep the first minimum
    always_ff @(posedge aclk) begin
        if (v4_reg && (idx4_reg == '0 || d4_reg < bestd_reg)) begin
            best_reg    <= idx4_reg;
            bestd_reg   <= d4_reg;
            bestblk_reg <= blk4_reg;
        end
    end

    // Image state updates
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            prev_reg    <= '0;
            run_reg     <= RW'(1);
            black_reg   <= '0;
            refused_reg <= 1'b0;
        end else begin
            if (cmd.init) begin
                count_reg   <= CW'(1);
                prev_reg    <= '0;
                run_reg     <= RW'(1);
                black_reg   <= '0;
                refused_reg <= 1'b0;
            end
            if (cmd.black && bestblk_reg && black_reg < apq_pkg::BLACK_MAX) begin
                black_reg <= black_reg + 1'b1;
            end
            if (cmd.run) begin
                if (best_reg != prev_reg) begin
                    run_reg <= RW'(1);
                end else if (run_reg < RUN_MAX) begin
                    run_reg <= run_reg + 1'b1;
                end
                prev_reg <= best_reg;
            end
            if (cmd.add) begin
                if (count_reg < DEPTH_C) begin
                    count_reg <= count_reg + 1'b1;
                end else begin
                    refused_reg <= 1'b1;
                end
            end
            if (cmd.fin) begin
                count_reg <= '0;
                prev_reg  <= '0;
                run_reg   <= RW'(1);
            end
        end
    end

    // Form the record selected by the command
    always_comb begin
        rec_kind  = 1'b0;
        rec_idx   = prev_reg;
        rec_run   = run_reg;
        rec_b     = '0;
        rec_g     = '0;
        rec_r     = '0;
        rec_black = black_reg;
        rec_full  = refused_reg;
        rec_fin   = cmd.fin;
        if (cmd.init || cmd.add) begin
            rec_kind = 1'b1;
            rec_idx  = cmd.init ? '0 : count_reg[IW-1:0];
            rec_run  = '0;
            rec_b    = pix_b_reg;
            rec_g    = pix_g_reg;
            rec_r    = pix_r_reg;
        end
        if (cmd.init) begin
            rec_black = '0;
            rec_full  = 1'b0;
        end
    end

    assign idx_ext = {8'd0, rec_idx};
    assign run_ext = {17'd0, rec_run};

    // Hold the record until the consumer takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            kind_reg      <= rec_kind;
            idx_out_reg   <= idx_ext[7:0];
            run_out_reg   <= run_ext[16:0];
            ob_reg        <= rec_b;
            og_reg        <= rec_g;
            or_reg        <= rec_r;
            black_out_reg <= rec_black;
            full_out_reg  <= rec_full;
            fin_out_reg   <= rec_fin;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_kind         = kind_reg;
    assign m_entry_index  = idx_out_reg;
    assign m_run_length   = run_out_reg;
    assign m_entry_blue   = ob_reg;
    assign m_entry_green  = og_reg;
    assign m_entry_red    = or_reg;
    assign m_black_count  = black_out_reg;
    assign m_palette_full = full_out_reg;
    assign m_final_record = fin_out_reg;

    // Status back to the controller
    assign status.first     = first_reg || (count_reg == '0);
    assign status.last      = last_reg;
    assign status.scan_done = !issuing_reg && !v1_reg && !v2_reg && !v3_reg && !v4_reg;
    assign status.run_brk   = (best_reg != prev_reg);
    assign status.add_req   = (bestd_reg >= thr_reg);
    assign status.has_room  = (count_reg < DEPTH_C);
    assign status.out_free  = !m_valid_reg || m_ready;

endmodule

// File: design/adaptive_palette_quantizer_rle.sv
// Top level of the adaptive palette quantizer with run-length coded output.
`timescale 1ns / 1ps
// Takes one BGR pixel at a time and emits up to three records per pixel:
// the run it closed, the palette entry it added, and the final run when
// last_pixel is set. For every later pixel the search reads one palette entry
// per cycle, over the N entries of the current palette (N up to PALETTE_DEPTH),
// from a memory with one write and one read port into a four-stage distance
// pipeline, followed by the black count, run, palette and final record
// steps. The opening pixel of an image skips the search. Each record waits
// in a one-entry output register; the block stalls only when a new record
// is due while that register is still held. The threshold may be written
// only while the block is idle.
module adaptive_palette_quantizer_rle #(
    parameter int PALETTE_DEPTH = 256,
    parameter int IMAGE_PIXELS  = 65536
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_blue,
    input  logic [7:0]  s_green,
    input  logic [7:0]  s_red,
    input  logic        s_first_pixel,
    input  logic        s_last_pixel,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [7:0]  m_entry_index,
    output logic [16:0] m_run_length,
    output logic [7:0]  m_entry_blue,
    output logic [7:0]  m_entry_green,
    output logic [7:0]  m_entry_red,
    output logic [15:0] m_black_count,
    output logic        m_palette_full,
    output logic        m_final_record
);

    apq_pkg::dp_cmd_t    cmd;
    apq_pkg::dp_status_t status;

    apq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    apq_dp #(
        .PALETTE_DEPTH (PALETTE_DEPTH),
        .IMAGE_PIXELS  (IMAGE_PIXELS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_blue         (s_blue),
        .s_green        (s_green),
        .s_red          (s_red),
        .s_first_pixel  (s_first_pixel),
        .s_last_pixel   (s_last_pixel),
        .cmd            (cmd),
        .status         (status),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_entry_index  (m_entry_index),
        .m_run_length   (m_run_length),
        .m_entry_blue   (m_entry_blue),
        .m_entry_green  (m_entry_green),
        .m_entry_red    (m_entry_red),
        .m_black_count  (m_black_count),
        .m_palette_full (m_palette_full),
        .m_final_record (m_final_record)
    );

endmodule
